// ----- hdl/rfw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfw_pkg
// Shared constants and types for the ring fifo with watermark block.
// ----------------------------------------------------------------------------
package rfw_pkg;

    // ring storage
    localparam int RING_SLOTS   = 64;
    localparam int DATA_WIDTH   = 32;
    localparam int MARKER_SLOTS = 2;
    localparam int PTR_W        = $clog2(RING_SLOTS);
    localparam int RING_W       = PTR_W + 1;

    // length register, occupancy and watermark fields
    localparam int LEN_W   = 6;
    localparam int CNT_W   = 6;
    localparam int STAT_W  = 2;
    localparam int LEN_CMP_W = (RING_W > LEN_W) ? RING_W : LEN_W + 1;
    localparam int LEN_MAX_I = RING_SLOTS - MARKER_SLOTS;
    localparam int LEN_RESET_I = (LEN_MAX_I > (2 ** LEN_W) - 1) ? (2 ** LEN_W) - 1 : LEN_MAX_I;
    localparam logic [LEN_CMP_W-1:0] LEN_MAX   = LEN_CMP_W'(LEN_MAX_I);
    localparam logic [LEN_W-1:0]     LEN_RESET = LEN_W'(LEN_RESET_I);

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = CMDQ_AW + 1;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                   op;
        logic [DATA_WIDTH-1:0] data;
    } t_cmd;

endpackage
`default_nettype wire

// ----- hdl/rfw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfw_front
// Accepts requests, decodes the action and buffers them in a short queue.
// ----------------------------------------------------------------------------
module rfw_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic [rfw_pkg::DATA_WIDTH-1:0] i_data_word,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output rfw_pkg::t_cmd                      o_cmd
);

    rfw_pkg::t_cmd                    r_q [rfw_pkg::CMDQ_DEPTH];
    logic [rfw_pkg::CMDQ_AW-1:0]      r_wr_ptr;
    logic [rfw_pkg::CMDQ_AW-1:0]      r_rd_ptr;
    logic [rfw_pkg::CMDQ_CW-1:0]      r_count;
    logic                             push;
    logic                             pop;
    rfw_pkg::t_cmd                    dec_cmd;

    // decode the incoming request
    always_comb begin
        dec_cmd.op   = i_action ? rfw_pkg::OP_DEQ : rfw_pkg::OP_ENQ;
        dec_cmd.data = i_data_word;
    end

    assign o_in_ready  = (r_count != rfw_pkg::CMDQ_CW'(rfw_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/rfw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfw_back
// Executes queued requests against the ring: pointers, counters, slot memory
// and the output register.
// ----------------------------------------------------------------------------
module rfw_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rfw_pkg::LEN_W-1:0]      i_cfg_data,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_ready,
    input  wire rfw_pkg::t_cmd                  i_cmd,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rfw_pkg::STAT_W-1:0]          o_status,
    output logic [rfw_pkg::DATA_WIDTH-1:0]      o_data_out,
    output logic [rfw_pkg::CNT_W-1:0]           o_used_count,
    output logic [rfw_pkg::CNT_W-1:0]           o_max_used
);

    // slot memory
    logic [rfw_pkg::DATA_WIDTH-1:0] mem [rfw_pkg::RING_SLOTS];
    logic [rfw_pkg::DATA_WIDTH-1:0] r_rd_data;

    // ring state
    logic [rfw_pkg::RING_W-1:0] r_ring_size;
    logic [rfw_pkg::PTR_W-1:0]  r_head;
    logic [rfw_pkg::PTR_W-1:0]  r_tail;
    logic [rfw_pkg::CNT_W-1:0]  r_occ;
    logic [rfw_pkg::CNT_W-1:0]  r_hw;

    // execute stage
    logic                       r_s1_valid;
    rfw_pkg::t_status           r_s1_status;
    logic                       r_s1_rd_ok;
    logic [rfw_pkg::CNT_W-1:0]  r_s1_occ;
    logic [rfw_pkg::CNT_W-1:0]  r_s1_hw;

    // output register
    logic                           r_out_valid;
    rfw_pkg::t_status               r_out_status;
    logic [rfw_pkg::DATA_WIDTH-1:0] r_out_data;
    logic [rfw_pkg::CNT_W-1:0]      r_out_occ;
    logic [rfw_pkg::CNT_W-1:0]      r_out_hw;

    logic                       pop;
    logic                       s1_adv;
    logic [rfw_pkg::RING_W-1:0] tail_inc;
    logic [rfw_pkg::RING_W-1:0] head_inc;
    logic [rfw_pkg::PTR_W-1:0]  tail_nxt;
    logic [rfw_pkg::PTR_W-1:0]  head_nxt;
    logic                       full;
    logic                       empty;
    logic                       wr_en;
    rfw_pkg::t_status           n_status;
    logic                       n_rd_ok;
    logic [rfw_pkg::CNT_W-1:0]  n_occ;
    logic [rfw_pkg::CNT_W-1:0]  n_hw;
    logic [rfw_pkg::LEN_CMP_W-1:0] cfg_len_w;
    logic [rfw_pkg::LEN_CMP_W-1:0] n_len;

    assign s1_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_ready = !r_s1_valid || s1_adv;
    assign pop         = i_cmd_valid && o_cmd_ready;

    // wrap the markers around the ring
    assign tail_inc = {1'b0, r_tail} + 1'b1;
    assign head_inc = {1'b0, r_head} + 1'b1;
    assign tail_nxt = (tail_inc >= r_ring_size) ? '0 : tail_inc[rfw_pkg::PTR_W-1:0];
    assign head_nxt = (head_inc >= r_ring_size) ? '0 : head_inc[rfw_pkg::PTR_W-1:0];
    assign full     = (tail_nxt == r_head);
    assign empty    = (head_nxt == r_tail);

    // classify the request and work out the new counters
    always_comb begin
        n_status = rfw_pkg::ST_OK;
        n_rd_ok  = 1'b0;
        n_occ    = r_occ;
        n_hw     = r_hw;
        wr_en    = 1'b0;
        unique case (i_cmd.op)
            rfw_pkg::OP_ENQ: begin
                if (full) begin
                    n_status = rfw_pkg::ST_FULL;
                end else begin
                    wr_en = pop;
                    n_occ = r_occ + 1'b1;
                    if (n_occ > r_hw) begin
                        n_hw = n_occ;
                    end
                end
            end
            rfw_pkg::OP_DEQ: begin
                if (empty) begin
                    n_status = rfw_pkg::ST_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                    if (r_occ != '0) begin
                        n_occ = r_occ - 1'b1;
                    end
                end
            end
            default: begin
                n_status = rfw_pkg::ST_OK;
            end
        endcase
    end

    // length write: zero taken as one, saturate to the largest usable length
    assign cfg_len_w = rfw_pkg::LEN_CMP_W'(i_cfg_data);
    always_comb begin
        priority if (cfg_len_w == '0) begin
            n_len = rfw_pkg::LEN_CMP_W'(1);
        end else if (cfg_len_w > rfw_pkg::LEN_MAX) begin
            n_len = rfw_pkg::LEN_MAX;
        end else begin
            n_len = cfg_len_w;
        end
    end

    // ring state and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= rfw_pkg::RING_W'(rfw_pkg::LEN_RESET) +
                           rfw_pkg::RING_W'(rfw_pkg::MARKER_SLOTS);
            r_head      <= '0;
            r_tail      <= rfw_pkg::PTR_W'(1);
            r_occ       <= '0;
            r_hw        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ring_size <= rfw_pkg::RING_W'(n_len) +
                               rfw_pkg::RING_W'(rfw_pkg::MARKER_SLOTS);
                r_head      <= '0;
                r_tail      <= rfw_pkg::PTR_W'(1);
                r_occ       <= '0;
                r_hw        <= '0;
            end else if (pop) begin
                if (wr_en) begin
                    r_tail <= tail_nxt;
                end
                if (n_rd_ok) begin
                    r_head <= head_nxt;
                end
                r_occ <= n_occ;
                r_hw  <= n_hw;
            end
            if (pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= i_cmd.data;
        end
        if (pop) begin
            r_rd_data <= mem[head_nxt];
        end
    end

    // execute stage and output payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_status <= n_status;
            r_s1_rd_ok  <= n_rd_ok;
            r_s1_occ    <= n_occ;
            r_s1_hw     <= n_hw;
        end
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_data   <= r_s1_rd_ok ? r_rd_data : '0;
            r_out_occ    <= r_s1_occ;
            r_out_hw     <= r_s1_hw;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_data_out   = r_out_data;
    assign o_used_count = r_out_occ;
    assign o_max_used   = r_out_hw;

endmodule
`default_nettype wire

// ----- hdl/ring_fifo_with_watermark.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_fifo_with_watermark
// Ring fifo of configurable length with occupancy and high-water reporting.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry one request, i_action selects
//   enqueue (0) or dequeue (1), i_data_word is the payload for an enqueue.
//   output channel: o_out_valid / i_out_ready carry one result per request:
//   o_status (ok, full, empty), o_data_out (dequeued word, zero otherwise),
//   o_used_count and o_max_used after the request.
//   config: pulse i_cfg_we with i_cfg_data = usable length (0 reads as 1,
//   large values saturate); this clears the pointers and both counters.
//   Write it only while no request is in flight.
//   path: a result passes through the request queue, the execute stage and the
//   output register, in that order, before it is presented.
//   throughput: one request per cycle unless i_out_ready stalls, set by the
//   execute stage, taking one queued request each cycle and updating the ring.
//   reset: length returns to its maximum, queue empty, watermark zero.
//   stall: a two-entry request queue and the execute and output registers
//   hold work while i_out_ready is low; o_in_ready drops once they are full.
// ----------------------------------------------------------------------------
module ring_fifo_with_watermark (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rfw_pkg::LEN_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_action,
    input  wire logic [rfw_pkg::DATA_WIDTH-1:0] i_data_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rfw_pkg::STAT_W-1:0]          o_status,
    output logic [rfw_pkg::DATA_WIDTH-1:0]      o_data_out,
    output logic [rfw_pkg::CNT_W-1:0]           o_used_count,
    output logic [rfw_pkg::CNT_W-1:0]           o_max_used
);

    logic          cmd_valid;
    logic          cmd_ready;
    rfw_pkg::t_cmd cmd;

    // request intake and queue
    rfw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_data_word (i_data_word),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // ring execution
    rfw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_ready  (cmd_ready),
        .i_cmd        (cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_data_out   (o_data_out),
        .o_used_count (o_used_count),
        .o_max_used   (o_max_used)
    );

endmodule
`default_nettype wire

// ----- hdl/rfw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfw_checker
// Port level checks for the ring fifo with watermark block.
// ----------------------------------------------------------------------------
module rfw_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [rfw_pkg::STAT_W-1:0]     o_status,
    input  wire logic [rfw_pkg::DATA_WIDTH-1:0] o_data_out,
    input  wire logic [rfw_pkg::CNT_W-1:0]      o_used_count,
    input  wire logic [rfw_pkg::CNT_W-1:0]      o_max_used
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // no reserved status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == rfw_pkg::ST_OK || o_status == rfw_pkg::ST_FULL ||
                         o_status == rfw_pkg::ST_EMPTY))
        else $error("reserved status code");

    // watermark never below occupancy
    a_watermark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_used_count <= o_max_used))
        else $error("occupancy above watermark");

    // refused requests return no data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != rfw_pkg::ST_OK) |-> (o_data_out == '0))
        else $error("data on refused request");

endmodule

bind ring_fifo_with_watermark rfw_checker u_rfw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_data_out   (o_data_out),
    .o_used_count (o_used_count),
    .o_max_used   (o_max_used)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring fifo with watermark. A shadow ring in the
// bench predicts status, dequeued word, occupancy and high-water mark for
// every accepted request. Directed cases come first, then fill and drain
// sweeps and bursty random traffic over many length settings, with the
// sender and the receiver both throttled.
// ----------------------------------------------------------------------------
module tb_top;
    import rfw_pkg::*;

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN,
        RDY_LONG
    } ready_mode_t;

    typedef struct {
        t_status               status;
        logic [DATA_WIDTH-1:0] word;
        logic [CNT_W-1:0]      used;
        logic [CNT_W-1:0]      peak;
    } fifo_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [LEN_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_action;
    logic [DATA_WIDTH-1:0] i_data_word;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [STAT_W-1:0]     o_status;
    logic [DATA_WIDTH-1:0] o_data_out;
    logic [CNT_W-1:0]      o_used_count;
    logic [CNT_W-1:0]      o_max_used;

    // shadow copy of the ring and its counters
    logic [DATA_WIDTH-1:0] shadow_slots [RING_SLOTS];
    logic [PTR_W-1:0]      shadow_head;
    logic [PTR_W-1:0]      shadow_tail;
    logic [CNT_W-1:0]      shadow_used;
    logic [CNT_W-1:0]      shadow_peak;
    int unsigned           ring_span;

    fifo_result_t expected_results [$];

    // pacing of both channels
    ready_mode_t ready_mode = RDY_ALWAYS;
    logic [7:0]  stall_tick = '0;
    int unsigned stall_left = 0;
    int unsigned gap_limit  = 0;
    int unsigned burst_left = 0;

    // run statistics
    int unsigned n_errors   = 0;
    int unsigned n_requests = 0;
    int unsigned n_full     = 0;
    int unsigned n_empty    = 0;
    int unsigned n_writes   = 0;
    int unsigned peak_seen  = 0;

    ring_fifo_with_watermark dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_data_word  (i_data_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_data_out   (o_data_out),
        .o_used_count (o_used_count),
        .o_max_used   (o_max_used)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
        int unsigned n;
        n = idx + 1;
        return (n >= ring_span) ? '0 : PTR_W'(n);
    endfunction

    // length write: clamp, resize the ring and clear pointers and counters
    function automatic void clear_ring(input logic [LEN_W-1:0] value);
        int unsigned len;
        len = value;
        if (len < 1)
            len = 1;
        if (len > RING_SLOTS - MARKER_SLOTS)
            len = RING_SLOTS - MARKER_SLOTS;
        ring_span   = len + MARKER_SLOTS;
        shadow_head = '0;
        shadow_tail = PTR_W'(1);
        shadow_used = '0;
        shadow_peak = '0;
    endfunction

    // apply one request to the shadow ring and return its result
    function automatic fifo_result_t fifo_apply(input t_op op,
                                                input logic [DATA_WIDTH-1:0] word);
        fifo_result_t r;
        logic [PTR_W-1:0] nxt;
        r.status = ST_OK;
        r.word   = '0;
        if (op == OP_ENQ) begin
            nxt = ring_next(shadow_tail);
            if (nxt == shadow_head) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                shadow_slots[shadow_tail] = word;
                shadow_tail = nxt;
                shadow_used++;
                if (shadow_used > shadow_peak)
                    shadow_peak = shadow_used;
            end
        end else begin
            nxt = ring_next(shadow_head);
            if (nxt == shadow_tail) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else begin
                r.word = shadow_slots[nxt];
                shadow_head = nxt;
                if (shadow_used != 0)
                    shadow_used--;
            end
        end
        if (shadow_peak > peak_seen)
            peak_seen = shadow_peak;
        r.used = shadow_used;
        r.peak = shadow_peak;
        return r;
    endfunction

    // present one request, wait for it to be taken, then maybe pause
    task automatic send_request(input t_op op, input logic [DATA_WIDTH-1:0] word);
        int unsigned gap;
        i_in_valid  <= 1'b1;
        i_action    <= op;
        i_data_word <= word;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        expected_results.push_back(fifo_apply(op, word));
        n_requests++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic program_length(input logic [LEN_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        clear_ring(value);
        n_writes++;
    endtask

    // receiver stall patterns
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (ready_mode)
            RDY_ALWAYS: begin
                i_out_ready <= 1'b1;
            end
            RDY_RANDOM: begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end
            RDY_PATTERN: begin
                i_out_ready <= (stall_tick[2:0] != 3'd5) && (stall_tick[5:3] != 3'd2);
            end
            default: begin
                if (stall_left != 0) begin
                    i_out_ready <= 1'b0;
                    stall_left  <= stall_left - 1;
                end else if ($urandom_range(0, 15) == 0) begin
                    i_out_ready <= 1'b0;
                    stall_left  <= $urandom_range(1, 24);
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        fifo_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d data %h",
                       o_status, o_data_out);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_errors++;
                end
                if (o_data_out !== want.word) begin
                    $error("data_out: expected %h, got %h", want.word, o_data_out);
                    n_errors++;
                end
                if (o_used_count !== want.used) begin
                    $error("used_count: expected %0d, got %0d", want.used, o_used_count);
                    n_errors++;
                end
                if (o_max_used !== want.peak) begin
                    $error("max_used: expected %0d, got %0d", want.peak, o_max_used);
                    n_errors++;
                end
            end
        end
    end

    // corner cases: empty and full refusals, data extremes, length clamping
    task automatic test_directed();
        gap_limit  = 0;
        ready_mode = RDY_ALWAYS;
        // reset length, dequeue from empty, words at both extremes
        send_request(OP_DEQ, '0);
        send_request(OP_ENQ, '0);
        send_request(OP_ENQ, '1);
        send_request(OP_ENQ, 32'hA5C3_0F69);
        repeat (3) send_request(OP_DEQ, $urandom());
        send_request(OP_DEQ, '1);
        // zero length reads as one entry
        program_length('0);
        send_request(OP_ENQ, 32'h8000_0001);
        send_request(OP_ENQ, 32'h7FFF_FFFE);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        // all-ones length saturates to the largest ring
        program_length('1);
        send_request(OP_ENQ, 32'h5555_5555);
        send_request(OP_DEQ, '0);
        // two entries: fill past full, drain past empty
        program_length(LEN_W'(2));
        repeat (3) send_request(OP_ENQ, $urandom());
        repeat (3) send_request(OP_DEQ, $urandom());
    endtask

    // fill each length to one past full and drain to one past empty
    task automatic test_fill_drain();
        logic [LEN_W-1:0] lengths [7];
        lengths = '{LEN_W'(1), LEN_W'(2), LEN_W'(3), LEN_W'(62), LEN_W'(31),
                    LEN_W'(32), LEN_W'($urandom_range(1, 62))};
        foreach (lengths[k]) begin
            ready_mode = ready_mode_t'(k % 4);
            gap_limit  = (k % 2) ? 4 : 0;
            program_length(lengths[k]);
            repeat (lengths[k] + 1) send_request(OP_ENQ, $urandom());
            repeat (lengths[k] + 1) send_request(OP_DEQ, $urandom());
        end
    endtask

    // bursty random traffic, runs of one direction long enough to hit both ends
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned run;
        int unsigned usable;
        logic [LEN_W-1:0] value;
        t_op op;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       value = LEN_W'(62);
                1:       value = LEN_W'(1);
                2:       value = '1;
                3:       value = LEN_W'($urandom_range(1, 6));
                default: value = LEN_W'($urandom_range(0, 63));
            endcase
            ready_mode = ready_mode_t'((phase + 1) % 4);
            gap_limit  = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 8);
            program_length(value);
            usable = ring_span - MARKER_SLOTS;
            sent   = 0;
            while (sent < 150) begin
                op  = t_op'($urandom_range(0, 1));
                run = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, usable + 2);
                repeat (run) begin
                    send_request(op, $urandom());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_action    = OP_ENQ;
        i_data_word = '0;
        clear_ring(LEN_RESET);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_drain();
        test_random_traffic();
        wait_drained();

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            n_errors++;
        end
        $display("%0d requests over %0d length writes: %0d refused as full, %0d as empty",
                 n_requests, n_writes, n_full, n_empty);
        $display("highest occupancy reached %0d, mismatches %0d", peak_seen, n_errors);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run time limit
    initial begin
        #10_000_000;
        $display("run did not finish within its time budget");
        $display("TEST FAILED");
        $finish;
    end

endmodule
